// File: rtl/glru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glru_pkg
// Shared constants and types of the glyph LRU tag store: key layout,
// operation codes and the update command sent to every tag cell.
// ----------------------------------------------------------------------------
package glru_pkg;

  // Default number of tag cells.
  localparam int CACHE_ENTRIES_DEF = 64;

  // Key: code point, point size, mono flag, rotation, lowest bits first.
  localparam int CP_W   = 21;
  localparam int SIZE_W = 16;
  localparam int ROT_W  = 2;
  localparam int KEY_W  = CP_W + SIZE_W + 1 + ROT_W;

  // Configuration register.
  localparam int CAP_W = 7;

  // Result field widths.
  localparam int SLOT_W = 6;
  localparam int OCC_W  = 7;

  // Operation codes carried in the request.
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Update command broadcast to every cell at the end of a request.
  typedef struct packed {
    logic clear;    // drop every entry
    logic promote;  // move the hit entry to most recent
    logic insert;   // write the new key and age the other entries
    logic evict;    // drop the least recent entry during an insert
  } apply_cmd_t;

  // Flags of the search result handed from cell to cell.
  typedef struct packed {
    logic hit;      // a valid entry matches the key
    logic free;     // a free cell has been seen
    logic lru;      // the entry with the target rank has been seen
  } scan_flags_t;

endpackage

// File: rtl/glru_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glru_cell
// One tag cell: holds a key, a valid bit and a recency rank, folds its own
// entry into the search result passed along the row, and applies the
// broadcast update command.
// ----------------------------------------------------------------------------
module glru_cell #(
  parameter int IW    = 6,
  parameter int RW    = 6,
  parameter int INDEX = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Search key and the rank of the least recent entry.
  input  logic [glru_pkg::KEY_W-1:0]          key_i,
  input  logic [RW-1:0]                       target_rank_i,
  // Search result from the previous cell.
  input  logic                                tok_i,
  input  glru_pkg::scan_flags_t               flags_i,
  input  logic [IW-1:0]                       hit_slot_i,
  input  logic [RW-1:0]                       hit_rank_i,
  input  logic [IW-1:0]                       free_slot_i,
  input  logic [IW-1:0]                       lru_slot_i,
  input  logic [glru_pkg::KEY_W-1:0]          lru_key_i,
  // Search result to the next cell.
  output logic                                tok_o,
  output glru_pkg::scan_flags_t               flags_o,
  output logic [IW-1:0]                       hit_slot_o,
  output logic [RW-1:0]                       hit_rank_o,
  output logic [IW-1:0]                       free_slot_o,
  output logic [IW-1:0]                       lru_slot_o,
  output logic [glru_pkg::KEY_W-1:0]          lru_key_o,
  // Update command.
  input  glru_pkg::apply_cmd_t                cmd_i,
  input  logic                                cmd_valid_i,
  input  logic [IW-1:0]                       new_slot_i,
  input  logic [IW-1:0]                       evict_slot_i,
  input  logic [IW-1:0]                       promote_slot_i,
  input  logic [RW-1:0]                       promote_rank_i
);
  import glru_pkg::*;

  localparam logic [IW-1:0] MY_SLOT = IW'(INDEX);

  logic [KEY_W-1:0] key_q;
  logic             valid_q, valid_d;
  logic [RW-1:0]    rank_q, rank_d;

  scan_flags_t      flags_q, flags_d;
  logic [IW-1:0]    hit_slot_q, hit_slot_d;
  logic [RW-1:0]    hit_rank_q, hit_rank_d;
  logic [IW-1:0]    free_slot_q, free_slot_d;
  logic [IW-1:0]    lru_slot_q, lru_slot_d;
  logic [KEY_W-1:0] lru_key_q, lru_key_d;
  logic             tok_q;
  logic             write_key;

  // Fold this entry into the running search result.
  always_comb begin
    flags_d     = flags_i;
    hit_slot_d  = hit_slot_i;
    hit_rank_d  = hit_rank_i;
    free_slot_d = free_slot_i;
    lru_slot_d  = lru_slot_i;
    lru_key_d   = lru_key_i;
    if (!flags_i.hit && valid_q && (key_q == key_i)) begin
      flags_d.hit = 1'b1;
      hit_slot_d  = MY_SLOT;
      hit_rank_d  = rank_q;
    end
    if (!flags_i.free && !valid_q) begin
      flags_d.free = 1'b1;
      free_slot_d  = MY_SLOT;
    end
    if (!flags_i.lru && valid_q && (rank_q == target_rank_i)) begin
      flags_d.lru = 1'b1;
      lru_slot_d  = MY_SLOT;
      lru_key_d   = key_q;
    end
  end

  // Token marks the cycle in which the result passes this cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i) begin
      flags_q     <= flags_d;
      hit_slot_q  <= hit_slot_d;
      hit_rank_q  <= hit_rank_d;
      free_slot_q <= free_slot_d;
      lru_slot_q  <= lru_slot_d;
      lru_key_q   <= lru_key_d;
    end
  end

  assign tok_o       = tok_q;
  assign flags_o     = flags_q;
  assign hit_slot_o  = hit_slot_q;
  assign hit_rank_o  = hit_rank_q;
  assign free_slot_o = free_slot_q;
  assign lru_slot_o  = lru_slot_q;
  assign lru_key_o   = lru_key_q;

  // Apply the broadcast update to this entry.
  always_comb begin
    valid_d   = valid_q;
    rank_d    = rank_q;
    write_key = 1'b0;
    if (cmd_valid_i) begin
      if (cmd_i.clear) begin
        valid_d = 1'b0;
        rank_d  = '0;
      end else if (cmd_i.promote) begin
        if (promote_slot_i == MY_SLOT) begin
          rank_d = '0;
        end else if (valid_q && (rank_q < promote_rank_i)) begin
          rank_d = rank_q + RW'(1);
        end
      end else if (cmd_i.insert) begin
        if (new_slot_i == MY_SLOT) begin
          write_key = 1'b1;
          valid_d   = 1'b1;
          rank_d    = '0;
        end else if (cmd_i.evict && (evict_slot_i == MY_SLOT)) begin
          valid_d = 1'b0;
          rank_d  = '0;
        end else if (valid_q) begin
          rank_d = rank_q + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_key) begin
      key_q <= key_i;
    end
  end

endmodule

// File: rtl/glyph_lru_cache_tags_core.sv
`timescale 1ns / 1ps
// The request is captured, then the search result walks the row of tag cells
// one cell per cycle; the update and the result register follow in the apply
// state, which waits while the result output is stalled. One request is in work
// at a time: a new request is taken only once the last one is through.
// Reset clears all valid bits, ranks and the entry count at once and sets
// capacity to 64; keys are undefined until written.
// ----------------------------------------------------------------------------
// glyph_lru_cache_tags_core
// Fully associative glyph tag store with least-recently-used replacement,
// built as a row of tag cells with a small sequencer and a result register.
// ----------------------------------------------------------------------------
module glyph_lru_cache_tags_core #(
  parameter int CACHE_ENTRIES = glru_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write: capacity.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [glru_pkg::CAP_W-1:0]    cfg_data_i,
  // Request stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // code_point[20:0], point_size[36:21], mono[37], rotation[39:38]
  input  logic [39:0]                   s_axis_tdata,
  // func[1:0]
  input  logic [1:0]                    s_axis_tuser,
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // slot[5:0], evicted_code_point[26:6], evicted_size[42:27],
  // evicted_mono[43], evicted_rotation[45:44], occupancy[52:46], zero[55:53]
  output logic [55:0]                   m_axis_tdata,
  // hit[0], evicted[1]
  output logic [1:0]                    m_axis_tuser
);
  import glru_pkg::*;

  localparam int N  = CACHE_ENTRIES;
  localparam int IW = $clog2(N);
  localparam int RW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(N);
  localparam logic [EW-1:0] N_EXT      = EW'(N);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_APPLY = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [1:0]       func_q;
  logic [KEY_W-1:0] key_q;
  logic [CW-1:0]    count_q, count_d;
  logic [CAP_W-1:0] cap_q;
  logic             start_q;
  logic             m_valid_q;
  logic [55:0]      m_data_q, m_data_d;
  logic [1:0]       m_user_q, m_user_d;

  logic             req_accept;
  logic             out_free;
  logic             apply_en;

  // Row signals, one more than the number of cells.
  logic             tok      [N+1];
  scan_flags_t      flags    [N+1];
  logic [IW-1:0]    hit_slot [N+1];
  logic [RW-1:0]    hit_rank [N+1];
  logic [IW-1:0]    free_slot[N+1];
  logic [IW-1:0]    lru_slot [N+1];
  logic [KEY_W-1:0] lru_key  [N+1];

  logic [CW-1:0]    target_count;
  logic [RW-1:0]    target_rank;
  apply_cmd_t       cmd;
  logic [IW-1:0]    new_slot;
  logic             is_lookup, is_clear, hit, full, over, evicted;
  logic [EW-1:0]    cap_ext, cap_eff, count_ext;
  logic [IW-1:0]    slot_idx;
  logic [IW+SLOT_W-1:0] slot_ext;
  logic [CW+OCC_W-1:0]  occ_ext;
  logic [KEY_W-1:0] ev_key;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign req_accept    = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign apply_en      = (state_q == ST_APPLY) && out_free;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_accept) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (tok[N]) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      start_q   <= 1'b0;
      count_q   <= '0;
      cap_q     <= CAP_W'(64);
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= req_accept;
      if (apply_en) begin
        count_q <= count_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (apply_en) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Request capture and result register.
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      func_q <= s_axis_tuser;
      key_q  <= s_axis_tdata;
    end
    if (apply_en) begin
      m_data_q <= m_data_d;
      m_user_q <= m_user_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // The least recent entry holds rank count - 1.
  assign target_count = count_q - CW'(1);
  assign target_rank  = target_count[RW-1:0];

  // Empty search result enters the first cell.
  assign tok[0]       = start_q;
  assign flags[0]     = '0;
  assign hit_slot[0]  = '0;
  assign hit_rank[0]  = '0;
  assign free_slot[0] = '0;
  assign lru_slot[0]  = '0;
  assign lru_key[0]   = '0;

  // Row of tag cells.
  for (genvar i = 0; i < N; i++) begin : g_cell
    glru_cell #(
      .IW    (IW),
      .RW    (RW),
      .INDEX (i)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .key_i          (key_q),
      .target_rank_i  (target_rank),
      .tok_i          (tok[i]),
      .flags_i        (flags[i]),
      .hit_slot_i     (hit_slot[i]),
      .hit_rank_i     (hit_rank[i]),
      .free_slot_i    (free_slot[i]),
      .lru_slot_i     (lru_slot[i]),
      .lru_key_i      (lru_key[i]),
      .tok_o          (tok[i+1]),
      .flags_o        (flags[i+1]),
      .hit_slot_o     (hit_slot[i+1]),
      .hit_rank_o     (hit_rank[i+1]),
      .free_slot_o    (free_slot[i+1]),
      .lru_slot_o     (lru_slot[i+1]),
      .lru_key_o      (lru_key[i+1]),
      .cmd_i          (cmd),
      .cmd_valid_i    (apply_en),
      .new_slot_i     (new_slot),
      .evict_slot_i   (lru_slot[N]),
      .promote_slot_i (hit_slot[N]),
      .promote_rank_i (hit_rank[N])
    );
  end

  // Effective capacity: zero acts as one, large values saturate.
  always_comb begin
    cap_ext = EW'(cap_q);
    if (cap_ext == '0) begin
      cap_eff = EW'(1);
    end else if (cap_ext > N_EXT) begin
      cap_eff = N_EXT;
    end else begin
      cap_eff = cap_ext;
    end
  end

  // Decide the update and the result from the search outcome.
  always_comb begin
    is_lookup   = func_q inside {FUNC_LOOKUP, FUNC_INSERT};
    is_clear    = (func_q == FUNC_CLEAR);
    hit         = is_lookup && flags[N].hit;
    full        = (count_q == FULL_COUNT);
    count_ext   = EW'(count_q);
    cmd.clear   = is_clear;
    cmd.promote = hit;
    cmd.insert  = (func_q == FUNC_INSERT) && !flags[N].hit;
    // Adding one entry would pass capacity when count already reaches it.
    over        = !full && (count_ext >= cap_eff);
    cmd.evict   = cmd.insert && over;
    evicted     = cmd.insert && (full || over);
    // A full store reuses the slot of the entry it evicts.
    new_slot    = full ? lru_slot[N] : free_slot[N];

    count_d = count_q;
    if (is_clear) begin
      count_d = '0;
    end else if (cmd.insert && !full && !over) begin
      count_d = count_q + CW'(1);
    end

    if (hit) begin
      slot_idx = hit_slot[N];
    end else if (cmd.insert) begin
      slot_idx = new_slot;
    end else begin
      slot_idx = '0;
    end

    slot_ext = {{SLOT_W{1'b0}}, slot_idx};
    occ_ext  = {{OCC_W{1'b0}}, count_d};
    ev_key   = evicted ? lru_key[N] : '0;
    m_data_d = {3'b000, occ_ext[OCC_W-1:0], ev_key, slot_ext[SLOT_W-1:0]};
    m_user_d = {evicted, hit};
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the glyph LRU tag store. Requests are driven on the
// slave stream and every result is checked field by field against a local
// model of the tag store. The run covers directed operations, several
// capacity settings and random lookup/insert traffic with idle and stall
// patterns on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import glru_pkg::*;

  localparam int CACHE_ENTRIES = CACHE_ENTRIES_DEF;
  localparam int LATENCY       = CACHE_ENTRIES + 3;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int HOLD_CYCLES   = 400;
  localparam int CP_MAX        = 1114111;

  // Operation code outside the defined set; the block answers it as a miss.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [ROT_W-1:0]  rot;
    logic              mono;
    logic [SIZE_W-1:0] pt_size;
    logic [CP_W-1:0]   cp;
  } glyph_key_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    glyph_key_t        victim;
    logic [OCC_W-1:0]  occupancy;
  } glyph_result_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [CAP_W-1:0] cfg_data_i    = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [39:0]      s_axis_tdata  = '0;
  logic [1:0]       s_axis_tuser  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [55:0]      m_axis_tdata;
  logic [1:0]       m_axis_tuser;

  // Local copy of the tag store.
  glyph_key_t       tag_key   [CACHE_ENTRIES];
  bit               tag_valid [CACHE_ENTRIES];
  int               tag_rank  [CACHE_ENTRIES];
  int               tag_count    = 0;
  logic [CAP_W-1:0] capacity_reg = 7'd64;

  glyph_result_t expected_results[$];
  glyph_key_t    key_pool[$];

  int error_count    = 0;
  int results_seen   = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int hold_left      = 0;

  glyph_lru_cache_tags_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // ------------------------------------------------------------------------
  // Tag store model
  // ------------------------------------------------------------------------

  // Valid entry with the highest rank, ignoring one slot.
  function automatic int oldest_entry(int skip);
    int best;
    best = -1;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (!tag_valid[i] || i == skip) continue;
      if (best < 0 || tag_rank[i] > tag_rank[best]) best = i;
    end
    return best;
  endfunction

  // Drops an entry, closes the gap in the ranks and returns its key.
  function automatic glyph_key_t evict_entry(int s);
    int rs;
    rs = tag_rank[s];
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (tag_valid[i] && tag_rank[i] > rs) tag_rank[i]--;
    end
    tag_valid[s] = 1'b0;
    tag_rank[s]  = 0;
    tag_count--;
    return tag_key[s];
  endfunction

  function automatic glyph_result_t predict_glyph_request(logic [1:0] op, glyph_key_t k);
    glyph_result_t r;
    int s;
    int v;
    int rs;
    int cap;
    r = '0;
    s = -1;
    case (op)
      FUNC_CLEAR: begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          tag_valid[i] = 1'b0;
          tag_rank[i]  = 0;
        end
        tag_count = 0;
      end
      FUNC_LOOKUP, FUNC_INSERT: begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (s < 0 && tag_valid[i] && tag_key[i] == k) s = i;
        end
        if (s >= 0) begin
          // Hit: move the entry to the front, everything newer ages by one.
          rs = tag_rank[s];
          for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (tag_valid[i] && tag_rank[i] < rs) tag_rank[i]++;
          end
          tag_rank[s] = 0;
          r.hit  = 1'b1;
          r.slot = s[SLOT_W-1:0];
        end else if (op == FUNC_INSERT) begin
          // A full store makes room before the new key goes in.
          if (tag_count >= CACHE_ENTRIES) begin
            v = oldest_entry(-1);
            if (v >= 0) begin
              r.victim  = evict_entry(v);
              r.evicted = 1'b1;
            end
          end
          for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (s < 0 && !tag_valid[i]) s = i;
          end
          if (s >= 0) begin
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
              if (tag_valid[i]) tag_rank[i]++;
            end
            tag_key[s]   = k;
            tag_valid[s] = 1'b1;
            tag_rank[s]  = 0;
            tag_count++;
            r.slot = s[SLOT_W-1:0];
            cap = int'(capacity_reg);
            if (cap < 1) cap = 1;
            if (cap > CACHE_ENTRIES) cap = CACHE_ENTRIES;
            // Over capacity: at most one eviction per insert.
            if (tag_count > cap && !r.evicted) begin
              v = oldest_entry(s);
              if (v >= 0) begin
                r.victim  = evict_entry(v);
                r.evicted = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.occupancy = tag_count[OCC_W-1:0];
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Key generation
  // ------------------------------------------------------------------------

  function automatic glyph_key_t random_glyph_key();
    glyph_key_t k;
    k.cp      = CP_W'($urandom_range(0, CP_MAX));
    k.pt_size = SIZE_W'($urandom_range(0, 65535));
    k.mono    = 1'($urandom_range(0, 1));
    k.rot     = ROT_W'($urandom_range(0, 3));
    return k;
  endfunction

  // A key that differs from the given one in a single field.
  function automatic glyph_key_t nearby_key(glyph_key_t k);
    glyph_key_t n;
    n = k;
    case ($urandom_range(0, 3))
      0: n.mono = ~k.mono;
      1: n.rot = k.rot ^ ROT_W'($urandom_range(1, 3));
      2: n.pt_size = k.pt_size ^ (SIZE_W'(1) << $urandom_range(0, SIZE_W - 1));
      default: begin
        n.cp = k.cp ^ (CP_W'(1) << $urandom_range(0, CP_W - 2));
        // Stay inside the code point range; fall back to the mono flag.
        if (n.cp > CP_MAX) begin
          n.cp   = k.cp;
          n.mono = ~k.mono;
        end
      end
    endcase
    return n;
  endfunction

  // ------------------------------------------------------------------------
  // Request driver and configuration
  // ------------------------------------------------------------------------

  // Offers one request and records its expected result once it is taken.
  // Idle gaps span up to a full request time so they land in every phase.
  task automatic send_glyph_request(input logic [1:0] op, input glyph_key_t k,
                                    output glyph_result_t want);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, LATENCY + 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= k;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    want = predict_glyph_request(op, k);
    expected_results.push_back(want);
  endtask

  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    capacity_reg = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ------------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= 100) begin
      $display("[%0t] result %0d: %s is %0h, predicted %0h", $time, results_seen, what,
               got, want);
    end
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Compare every accepted result with the oldest expected one.
  always @(posedge clk_i) begin
    glyph_result_t got;
    glyph_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.hit            = m_axis_tuser[0];
      got.evicted        = m_axis_tuser[1];
      got.slot           = m_axis_tdata[5:0];
      got.victim.cp      = m_axis_tdata[26:6];
      got.victim.pt_size = m_axis_tdata[42:27];
      got.victim.mono    = m_axis_tdata[43];
      got.victim.rot     = m_axis_tdata[45:44];
      got.occupancy      = m_axis_tdata[52:46];
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, '0);
      end else begin
        want = expected_results.pop_front();
        check_field("hit", got.hit, want.hit);
        check_field("slot", got.slot, want.slot);
        check_field("evicted", got.evicted, want.evicted);
        check_field("evicted code point", got.victim.cp, want.victim.cp);
        check_field("evicted size", got.victim.pt_size, want.victim.pt_size);
        check_field("evicted mono", got.victim.mono, want.victim.mono);
        check_field("evicted rotation", got.victim.rot, want.victim.rot);
        check_field("occupancy", got.occupancy, want.occupancy);
        check_field("padding", m_axis_tdata[55:53], '0);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Render-style traffic: mostly a lookup followed by an insert on a miss,
  // mixed with direct inserts, near-miss keys, fresh keys, clears and the
  // unused operation code.
  task automatic run_render_phase(input logic [CAP_W-1:0] cap, input int idle_pct,
                                  input int stall_pct, input int items,
                                  input int pool_size, input int clear_pct);
    glyph_result_t r;
    glyph_key_t    k;
    int            sent;
    int            sel;
    wait_until_idle();
    set_capacity(cap);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    key_pool.delete();
    for (int i = 0; i < pool_size; i++) key_pool.push_back(random_glyph_key());
    sent = 0;
    while (sent < items) begin
      sel = $urandom_range(0, 99);
      k   = key_pool[$urandom_range(0, pool_size - 1)];
      if (sel < clear_pct) begin
        send_glyph_request(FUNC_CLEAR, random_glyph_key(), r);
        sent++;
      end else if (sel < 70) begin
        send_glyph_request(FUNC_LOOKUP, k, r);
        sent++;
        if (!r.hit && $urandom_range(0, 9) != 0) begin
          send_glyph_request(FUNC_INSERT, k, r);
          sent++;
        end
      end else if (sel < 82) begin
        send_glyph_request(FUNC_INSERT, k, r);
        sent++;
      end else if (sel < 91) begin
        send_glyph_request($urandom_range(0, 1) ? FUNC_INSERT : FUNC_LOOKUP,
                           nearby_key(k), r);
        sent++;
      end else if (sel < 98) begin
        send_glyph_request($urandom_range(0, 1) ? FUNC_INSERT : FUNC_LOOKUP,
                           random_glyph_key(), r);
        sent++;
      end else begin
        send_glyph_request(FUNC_UNUSED, k, r);
        sent++;
      end
    end
  endtask

  // Each operation on the empty and lightly filled store, field extremes.
  task automatic test_basic_operations();
    glyph_result_t r;
    glyph_key_t    kmax;
    glyph_key_t    kzero;
    glyph_key_t    k;
    kmax  = '{rot: 2'd3, mono: 1'b1, pt_size: 16'hFFFF, cp: CP_W'(CP_MAX)};
    kzero = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_glyph_request(FUNC_LOOKUP, kzero, r);
    send_glyph_request(FUNC_INSERT, kmax, r);
    send_glyph_request(FUNC_INSERT, kzero, r);
    send_glyph_request(FUNC_LOOKUP, kmax, r);
    send_glyph_request(FUNC_INSERT, kmax, r);
    k = kmax;
    k.mono = 1'b0;
    send_glyph_request(FUNC_LOOKUP, k, r);
    k = kmax;
    k.rot = 2'd2;
    send_glyph_request(FUNC_LOOKUP, k, r);
    send_glyph_request(FUNC_UNUSED, kzero, r);
    send_glyph_request(FUNC_CLEAR, kmax, r);
    send_glyph_request(FUNC_LOOKUP, kmax, r);
  endtask

  // Replacement order at the smallest capacities.
  task automatic test_eviction_order();
    glyph_result_t r;
    glyph_key_t    ka;
    glyph_key_t    kb;
    glyph_key_t    kc;
    ka = random_glyph_key();
    kb = nearby_key(ka);
    kc = random_glyph_key();
    wait_until_idle();
    set_capacity(7'd1);
    send_glyph_request(FUNC_INSERT, ka, r);
    send_glyph_request(FUNC_INSERT, kb, r);
    send_glyph_request(FUNC_LOOKUP, ka, r);
    send_glyph_request(FUNC_LOOKUP, kb, r);
    wait_until_idle();
    set_capacity(7'd2);
    send_glyph_request(FUNC_INSERT, ka, r);
    send_glyph_request(FUNC_LOOKUP, kb, r);
    send_glyph_request(FUNC_INSERT, kc, r);
    send_glyph_request(FUNC_LOOKUP, ka, r);
    send_glyph_request(FUNC_LOOKUP, kb, r);
    send_glyph_request(FUNC_CLEAR, kc, r);
  endtask

  // Working set larger than the store so it fills and replaces when full.
  task automatic test_full_store();
    run_render_phase(7'd64, 0, 0, 300, 80, 0);
  endtask

  // Capacity dropped below a full store: each insert that misses evicts one entry.
  task automatic test_capacity_shrink();
    run_render_phase(7'd5, 64, 0, 300, 8, 0);
  endtask

  // Capacity one and zero behave alike.
  task automatic test_capacity_floor();
    run_render_phase(7'd1, 0, 64, 200, 3, 1);
    run_render_phase(7'd0, 34, 34, 100, 3, 1);
  endtask

  // Capacity above the store size is limited by the number of entries.
  task automatic test_capacity_ceiling();
    run_render_phase(7'd127, 34, 34, 300, 90, 1);
  endtask

  task automatic test_random_mix();
    run_render_phase(CAP_W'($urandom_range(2, 63)), 0, 0, 150, 30, 1);
    run_render_phase(CAP_W'($urandom_range(2, 63)), 34, 34, 150, 40, 1);
  endtask

  // The result side holds off for a long stretch while requests keep coming.
  task automatic test_output_hold();
    wait_until_idle();
    @(posedge clk_i);
    hold_requests++;
    run_render_phase(7'd64, 0, 0, 60, 70, 0);
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("glyph_lru_cache_tags_core: mismatch");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_operations();
    test_eviction_order();
    test_full_store();
    test_capacity_shrink();
    test_capacity_floor();
    test_capacity_ceiling();
    test_random_mix();
    test_output_hold();
    wait_until_idle();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("glyph_lru_cache_tags_core: match");
    end else begin
      $display("glyph_lru_cache_tags_core: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/glru_pkg.sv
rtl/glru_cell.sv
rtl/glyph_lru_cache_tags_core.sv
tb/sv/testbench.sv
